// File: sv/tlp_pkg.sv
package tlp_pkg;

	// Field widths fixed by the interface.
	localparam int PocW  = 16;
	localparam int GopW  = 17;	// effective GOP size, 65536 when programmed as zero
	localparam int TgW   = 7;
	localparam int TW    = 6;
	localparam int ModeW = 2;
	localparam int ClsW  = 2;
	localparam int IdxW  = 2;
	localparam int DataW = 16;

	localparam int PocBitsDef = 16;

	// Register indexes on the configuration port.
	localparam logic [IdxW-1:0] REG_GOP_SIZE  = 2'd0;
	localparam logic [IdxW-1:0] REG_TGOP_SIZE = 2'd1;
	localparam logic [IdxW-1:0] REG_REF_MODE  = 2'd2;

	// Reference modes. The fourth code behaves as jump.
	localparam logic [ModeW-1:0] MODE_ADJ     = 2'd0;
	localparam logic [ModeW-1:0] MODE_JUMP    = 2'd1;
	localparam logic [ModeW-1:0] MODE_UNIFORM = 2'd2;

	// Disposability classes.
	localparam logic [ClsW-1:0] CLS_KEEP     = 2'd0;
	localparam logic [ClsW-1:0] CLS_DROP     = 2'd1;
	localparam logic [ClsW-1:0] CLS_DROP_EXT = 2'd2;

	// Register reset values.
	localparam logic [15:0]      GOP_SIZE_RST  = 16'd60;
	localparam logic [TgW-1:0]   TGOP_SIZE_RST = 7'd4;
	localparam logic [ModeW-1:0] REF_MODE_RST  = MODE_ADJ;

	// Largest temporal group size.
	localparam logic [TgW-1:0] TGOP_MAX = 7'd64;

	// Effective configuration as seen by the datapath.
	typedef struct packed {
		logic [GopW-1:0]  gop;
		logic [TgW-1:0]   tg;
		logic [ModeW-1:0] mode;
	} cfg_t;

	// Frame positions handed from the tracker to the decision stage.
	typedef struct packed {
		logic [PocW-1:0] poc;
		logic [TW-1:0]   t;
	} slot_t;

endpackage

// File: sv/tlp_track.sv
module tlp_track import tlp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  recalc,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  idr_request,
	input  logic  s1_take,
	output logic  s1_valid,
	output slot_t slot_s1
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POC  = 2'd1;
	localparam logic [1:0] ST_TMP  = 2'd2;
	localparam int DivSteps = PocW;
	localparam int StepW = $clog2(DivSteps);
	localparam logic [StepW-1:0] STEP_LAST = StepW'(DivSteps - 1);

	logic [1:0]       state_q;
	logic [StepW-1:0] step_q;
	logic [PocW-1:0]  poc_q;
	logic [PocW-1:0]  raw_poc_q;
	logic [TW-1:0]    t_q;
	logic [GopW-1:0]  rem_q;
	logic [PocW-1:0]  dvd_q;
	logic             s1_valid_q;

	logic             accept;
	logic [PocW-1:0]  cur_poc;
	logic [TW-1:0]    cur_t;
	logic [GopW-1:0]  poc_inc;
	logic [TgW-1:0]   t_inc;
	logic             poc_wrap;
	logic [GopW:0]    trial;
	logic [GopW:0]    divisor;
	logic [GopW:0]    trial_sub;
	logic [GopW-1:0]  rem_nxt;

	assign in_ready = (state_q == ST_IDLE) && !recalc && (!s1_valid_q || s1_take);
	assign accept   = in_valid && in_ready;
	assign s1_valid = s1_valid_q;

	// Position of the accepted frame; an IDR request restarts at zero.
	assign cur_poc  = idr_request ? '0 : poc_q;
	assign cur_t    = idr_request ? '0 : t_q;
	assign poc_inc  = GopW'(cur_poc) + GopW'(1);
	assign t_inc    = TgW'(cur_t) + TgW'(1);
	assign poc_wrap = poc_inc >= cfg.gop;

	// One restoring remainder step per cycle, used after a register write.
	assign trial     = {rem_q, dvd_q[PocW-1]};
	assign divisor   = (state_q == ST_POC) ? (GopW+1)'(cfg.gop) : (GopW+1)'(cfg.tg);
	assign trial_sub = trial - divisor;
	assign rem_nxt   = (trial >= divisor) ? trial_sub[GopW-1:0] : trial[GopW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			poc_q      <= '0;
			raw_poc_q  <= '0;
			t_q        <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_take) begin
				s1_valid_q <= 1'b0;
			end

			if (recalc) begin
				state_q <= ST_POC;
				step_q  <= '0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (accept) begin
							// The unreduced copy only moves with frames, so that a
							// series of writes reduces against the final GOP size.
							poc_q     <= poc_wrap ? '0 : poc_inc[PocW-1:0];
							raw_poc_q <= poc_wrap ? '0 : poc_inc[PocW-1:0];
							if (poc_wrap || (t_inc == cfg.tg)) begin
								t_q <= '0;
							end else begin
								t_q <= t_inc[TW-1:0];
							end
						end
					end
					ST_POC: begin
						step_q <= step_q + StepW'(1);
						if (step_q == STEP_LAST) begin
							poc_q   <= rem_nxt[PocW-1:0];
							state_q <= ST_TMP;
							step_q  <= '0;
						end
					end
					ST_TMP: begin
						step_q <= step_q + StepW'(1);
						if (step_q == STEP_LAST) begin
							t_q     <= rem_nxt[TW-1:0];
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// Divider datapath and the stage register hold no control state.
	always_ff @(posedge clk) begin
		if (recalc) begin
			rem_q <= '0;
			dvd_q <= raw_poc_q;
		end else if (state_q == ST_POC && step_q == STEP_LAST) begin
			rem_q <= '0;
			dvd_q <= rem_nxt[PocW-1:0];
		end else begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[PocW-2:0], 1'b0};
		end

		if (accept) begin
			slot_s1.poc <= cur_poc;
			slot_s1.t   <= cur_t;
		end
	end

endmodule

// File: sv/tlp_decide.sv
module tlp_decide import tlp_pkg::*; #(
	parameter int POC_BITS = PocBitsDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            s1_valid,
	input  slot_t           slot_s1,
	output logic            s1_take,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [PocW-1:0] frame_poc,
	output logic            mark_ltr,
	output logic            use_ltr,
	output logic [PocW-1:0] ref_poc,
	output logic [ClsW-1:0] drop_class
);

	localparam int OutW = (POC_BITS < PocW) ? POC_BITS : PocW;

	logic [TW-1:0]   t;
	logic [PocW-1:0] poc;
	logic [TW-1:0]   low_bit;
	logic            is_uniform;
	logic            is_adj;
	logic            mark_d;
	logic            use_d;
	logic [PocW-1:0] ref_d;
	logic [ClsW-1:0] cls_d;
	logic [TgW-1:0]  tg_last;
	logic [GopW-1:0] gop_last;

	logic            out_valid_q;
	logic [OutW-1:0] poc_q;
	logic [OutW-1:0] ref_q;
	logic            mark_q;
	logic            use_q;
	logic [ClsW-1:0] cls_q;

	assign t          = slot_s1.t;
	assign poc        = slot_s1.poc;
	assign low_bit    = t & (~t + TW'(1));
	assign is_uniform = cfg.mode == MODE_UNIFORM;
	assign is_adj     = cfg.mode == MODE_ADJ;
	assign tg_last    = cfg.tg - TgW'(1);
	assign gop_last   = cfg.gop - GopW'(1);

	always_comb begin
		mark_d = 1'b0;
		use_d  = 1'b0;
		ref_d  = poc - PocW'(1);
		if (t == '0) begin
			// Start of a temporal group: mark it and point back one group.
			mark_d = 1'b1;
			use_d  = poc != '0;
			ref_d  = use_d ? (poc - PocW'(cfg.tg)) : '0;
		end else if (!is_uniform) begin
			if (t != TW'(1) && !is_adj) begin
				use_d = 1'b1;
				ref_d = poc - PocW'(t);
			end
		end else if (!t[0]) begin
			use_d  = 1'b1;
			mark_d = t[1:0] == 2'b00;
			ref_d  = poc - PocW'(low_bit);
		end

		if (!is_uniform) begin
			if (mark_d) begin
				cls_d = CLS_KEEP;
			end else if (is_adj && TgW'(t) != tg_last && GopW'(poc) != gop_last) begin
				cls_d = CLS_DROP_EXT;
			end else begin
				cls_d = CLS_DROP;
			end
		end else if (t[0]) begin
			cls_d = CLS_DROP;
		end else if (t != '0) begin
			cls_d = CLS_DROP_EXT;
		end else begin
			cls_d = CLS_KEEP;
		end
	end

	assign s1_take = s1_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			poc_q  <= poc[OutW-1:0];
			ref_q  <= ref_d[OutW-1:0];
			mark_q <= mark_d;
			use_q  <= use_d;
			cls_q  <= cls_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_poc  = PocW'(poc_q);
	assign ref_poc    = PocW'(ref_q);
	assign mark_ltr   = mark_q;
	assign use_ltr    = use_q;
	assign drop_class = cls_q;

endmodule

// File: sv/temporal_layer_ltr_planner_unit.sv
// Temporal-layer long-term reference planner. Each request on the input
// channel stands for one encoded frame and yields exactly one result: the
// frame's position in its GOP, whether the frame is marked long-term, whether
// it references a long-term frame, the POC of its reference and its
// disposability class. A frame is taken in every cycle while input ready is
// high (tracker idle, tracking register free or emptying); the tracking
// register takes the request at the accepting edge and the result register
// loads it once the output is free or read. The result register lets a new
// request enter while an earlier result still waits on the output. After any
// register write the block re-derives the stored positions (16 remainder
// steps against the GOP size, then 16 against the temporal group size), with
// input ready low; writes are accepted at all times and restart that pass. A
// GOP size of zero acts as 65536, a temporal group size of zero acts as one
// and anything above 64 acts as 64, and reference mode three behaves as jump
// mode. POC_BITS sets only the output POC width, up to 16 low bits; the POC arithmetic is 16 bits wide.
module temporal_layer_ltr_planner_unit import tlp_pkg::*; #(
	parameter int POC_BITS = PocBitsDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [DataW-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             idr_request,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PocW-1:0]  frame_poc,
	output logic             mark_ltr,
	output logic             use_ltr,
	output logic [PocW-1:0]  ref_poc,
	output logic [ClsW-1:0]  drop_class
);

	// Programmed register values, stored as written.
	logic [15:0]      gop_size_q;
	logic [TgW-1:0]   tgop_size_q;
	logic [ModeW-1:0] ref_mode_q;

	logic  cfg_write;
	cfg_t  cfg;
	logic  s1_valid;
	logic  s1_take;
	slot_t slot_s1;

	// The configuration channel never stalls.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gop_size_q  <= GOP_SIZE_RST;
			tgop_size_q <= TGOP_SIZE_RST;
			ref_mode_q  <= REF_MODE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_GOP_SIZE:  gop_size_q  <= cfg_data;
				REG_TGOP_SIZE: tgop_size_q <= cfg_data[TgW-1:0];
				REG_REF_MODE:  ref_mode_q  <= cfg_data[ModeW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Map the programmed values onto their effective ranges.
	always_comb begin
		cfg.gop  = (gop_size_q == '0) ? (GopW'(1) << PocW) : GopW'(gop_size_q);
		cfg.mode = ref_mode_q;
		if (tgop_size_q == '0) begin
			cfg.tg = TgW'(1);
		end else if (tgop_size_q > TGOP_MAX) begin
			cfg.tg = TGOP_MAX;
		end else begin
			cfg.tg = tgop_size_q;
		end
	end

	// Position counters, the per-frame stage register and the re-derivation
	// pass that runs after each register write.
	tlp_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.recalc      (cfg_write),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.idr_request (idr_request),
		.s1_take     (s1_take),
		.s1_valid    (s1_valid),
		.slot_s1     (slot_s1)
	);

	// Reference decision and the result register.
	tlp_decide #(
		.POC_BITS (POC_BITS)
	) u_decide (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.s1_valid   (s1_valid),
		.slot_s1    (slot_s1),
		.s1_take    (s1_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_poc  (frame_poc),
		.mark_ltr   (mark_ltr),
		.use_ltr    (use_ltr),
		.ref_poc    (ref_poc),
		.drop_class (drop_class)
	);

endmodule
